>>> rtl/core/ilid_pkg.sv
// Shared types and constants for the indexed list block.
// No dependencies; imported by ilid_cell and indexed_list_insert_delete.
`default_nettype none

package ilid_pkg;

   localparam int OPCODE_W   = 3;
   localparam int POSITION_W = 7;
   localparam int DATA_W     = 16;
   localparam int READ_W     = 17;
   localparam int STATUS_W   = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_READ       = 3'd0,
      OP_INS_HEAD   = 3'd1,
      OP_INS_TAIL   = 3'd2,
      OP_INS_BEFORE = 3'd3,
      OP_DELETE     = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   localparam logic signed [READ_W-1:0] NO_VALUE = -17'sd1;

   typedef struct packed {
      logic [OPCODE_W-1:0]   opcode;
      logic [POSITION_W-1:0] position;
      logic [DATA_W-1:0]     data_value;
   } req_type;

   typedef struct packed {
      logic signed [READ_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
   } rsp_type;

   // Shift command broadcast to every cell of the chain.
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [DATA_W-1:0] data;
   } cell_cmd_type;

endpackage

`default_nettype wire

>>> rtl/core/ilid_cell.sv
// One storage cell of the list chain: holds the entry at a fixed position.
// Depends on ilid_pkg for the broadcast command type.
`default_nettype none

module ilid_cell import ilid_pkg::*; #(
   parameter int INDEX   = 0,
   parameter int POS_W   = 7,
   parameter int STORE_W = 16
) (
   input  wire logic               clock,
   input  wire cell_cmd_type       cmd,
   input  wire logic [POS_W-1:0]   pos,
   input  wire logic [STORE_W-1:0] lower_value,
   input  wire logic [STORE_W-1:0] upper_value,
   output logic      [STORE_W-1:0] value,
   output logic      [STORE_W-1:0] read_term
);

   logic [STORE_W-1:0] value_ff;
   logic [STORE_W-1:0] value_in;
   logic               above;
   logic               here;

   assign above = 32'(pos) < INDEX;
   assign here  = 32'(pos) == INDEX;

   // Insert moves the cells above the position up by one place and writes the new
   // value at the position; delete pulls the cells at and above the position down by one place.
   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (above) begin
            value_in = lower_value;
         end else if (here) begin
            value_in = cmd.data[STORE_W-1:0];
         end
      end else if (cmd.del) begin
         if (above || here) begin
            value_in = upper_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_term = here ? value_ff : '0;

endmodule

`default_nettype wire

>>> rtl/core/indexed_list_insert_delete.sv
// Top level of the indexed list: a chain of cells plus length and result logic.
// Depends on ilid_pkg and ilid_cell.
`default_nettype none

// Ordered list of up to CAPACITY values addressed by position. Every
// operation (read, insert at head, tail or before a position, delete) is
// carried out at the transfer edge: all cells of the chain shift or hold in
// parallel, so busy stays low and a new command may be issued every
// cycle. The result appears on rsp_data with rsp_valid high for exactly one
// cycle, the cycle after the command transfer; the receiver cannot stall it.
// Entries above the current length hold stale data and are never returned.
module indexed_list_insert_delete import ilid_pkg::*; #(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam int LEN_W   = $clog2(CAPACITY + 1);
   localparam int POS_W   = (LEN_W > POSITION_W) ? LEN_W : POSITION_W;
   localparam int STORE_W = (VALUE_WIDTH < DATA_W) ? VALUE_WIDTH : DATA_W;

   logic [LEN_W-1:0]   len_ff;
   logic [LEN_W-1:0]   len_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic               accept;
   logic [POS_W-1:0]   len_x;
   logic [POS_W-1:0]   req_pos_x;
   logic [POS_W-1:0]   cell_pos;
   cell_cmd_type       cmd;
   logic [STORE_W-1:0] read_word;

   logic [STORE_W-1:0] cell_value [CAPACITY];
   logic [STORE_W-1:0] cell_read  [CAPACITY];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign len_x     = POS_W'(len_ff);
   assign req_pos_x = POS_W'(req_data.position);

   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_read[i];
      end
   end

   always_comb begin
      cmd          = '0;
      cmd.data     = req_data.data_value;
      cell_pos     = req_pos_x;
      len_in       = len_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = accept;
      if (accept) begin
         rsp_in.read_value = NO_VALUE;
         rsp_in.status     = ST_DONE;
         unique case (req_data.opcode) inside
            OP_READ: begin
               if (req_pos_x < len_x) begin
                  rsp_in.read_value = signed'(READ_W'(read_word));
               end else begin
                  rsp_in.status = ST_INVALID;
               end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_BEFORE: begin
               if (req_data.opcode == OP_INS_HEAD) begin
                  cell_pos = '0;
               end else if (req_data.opcode == OP_INS_TAIL) begin
                  cell_pos = len_x;
               end
               if (cell_pos > len_x) begin
                  rsp_in.status = ST_INVALID;
               end else if (32'(len_ff) >= CAPACITY) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  cmd.ins = 1'b1;
                  len_in  = len_ff + LEN_W'(1);
               end
            end
            OP_DELETE: begin
               if (req_pos_x < len_x) begin
                  cmd.del = 1'b1;
                  len_in  = len_ff - LEN_W'(1);
               end else begin
                  rsp_in.status = ST_INVALID;
               end
            end
            default: begin
               rsp_in.status = ST_INVALID;
            end
         endcase
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [STORE_W-1:0] lower;
      logic [STORE_W-1:0] upper;
      if (g == 0) begin : g_first
         assign lower = req_data.data_value[STORE_W-1:0];
      end else begin : g_mid_lo
         assign lower = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = cell_value[g];
      end else begin : g_mid_hi
         assign upper = cell_value[g+1];
      end
      ilid_cell #(
         .INDEX   (g),
         .POS_W   (POS_W),
         .STORE_W (STORE_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos         (cell_pos),
         .lower_value (lower),
         .upper_value (upper),
         .value       (cell_value[g]),
         .read_term   (cell_read[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result follows every command transfer in the next cycle.
   a_rsp_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("result strobe missing after a command transfer");

   // The list never grows past its capacity.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= CAPACITY)
      else $error("list length above capacity");

   // A full report leaves the length at capacity and returns no value.
   a_full_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
         (32'(len_ff) == CAPACITY && rsp_data.read_value == NO_VALUE))
      else $error("full status without a full list");

   // The length moves by at most one per cycle.
   a_len_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(len_ff) |->
         (len_ff == $past(len_ff) + LEN_W'(1) || len_ff == $past(len_ff) - LEN_W'(1)))
      else $error("list length jumped by more than one");

endmodule

`default_nettype wire
